// ----- src/w2mp_pkg.sv -----
// ----------------------------------------------------------------------------
// w2mp_pkg
// Shared constants, types and tables for the world-to-map pixel pipeline.
// ----------------------------------------------------------------------------
package w2mp_pkg;

  // Map geometry
  localparam int unsigned MAP_SIZE = 1024;
  localparam int unsigned MAP_HALF = MAP_SIZE / 2;
  localparam int unsigned QW       = $clog2(MAP_SIZE);

  // Field widths
  localparam int unsigned LON_W   = 25;
  localparam int unsigned LAT_W   = 24;
  localparam int unsigned LEN_W   = 24;
  localparam int unsigned MPD_W   = 25;
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned DLT_W   = 25;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned COS_W   = 31;
  localparam int unsigned X2_W    = 32;
  localparam int unsigned OFS_W   = 50;
  localparam int unsigned CELL_SH = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_LON = 3'd0,
    REG_CENTER_LAT = 3'd1,
    REG_NODE_W     = 3'd2,
    REG_NODE_H     = 3'd3,
    REG_MPD        = 3'd4
  } cfg_idx_e;

  localparam logic [LEN_W-1:0] NODE_RST = 24'd38400;
  localparam logic [MPD_W-1:0] MPD_RST  = 25'd28446720;

  // Angle constants, 2^-16 degree units
  localparam logic [LON_W-1:0]        DEG360   = 25'd23592960;
  localparam logic signed [26:0]      LON_180S = 27'sd11796480;
  localparam logic signed [26:0]      LON_360S = 27'sd23592960;
  localparam logic [SUM_W-1:0]        DEG90X2  = 24'd11796480;
  localparam logic signed [LAT_W-1:0] LAT_MIN  = -24'sd5898240;
  localparam logic signed [LAT_W-1:0] LAT_MAX  = 24'sd5898240;

  // pi/180 in Q32 and one in Q30
  localparam logic [26:0]      RAD_PER_DEG = 27'd74961321;
  localparam logic [COS_W-1:0] ONE_Q30     = 31'h4000_0000;

  // Taylor divisors of the cosine series and floor(2^32 / divisor)
  localparam int unsigned HORNER_N = 7;
  localparam logic [7:0] HORNER_DIV [HORNER_N] = '{
    8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
  };
  localparam logic [31:0] HORNER_RCP [HORNER_N] = '{
    32'd23598721, 32'd32537631, 32'd47721858, 32'd76695844,
    32'd143165576, 32'd357913941, 32'd2147483648
  };

  localparam logic [PIX_W-1:0] PIX_NONE = 16'hFFFF;

  // Values that ride alongside the cosine
  typedef struct packed {
    logic signed [DLT_W-1:0] dlon;
    logic signed [DLT_W-1:0] dlat;
    logic                    bad;
  } side_t;

  // Result item
  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic             outside_map;
    logic             bad_coordinate;
  } pix_t;

endpackage

// ----- src/w2mp_pos_if.sv -----
// ----------------------------------------------------------------------------
// w2mp_pos_if
// Position channel: valid/ready handshake with longitude and latitude.
// ----------------------------------------------------------------------------
interface w2mp_pos_if;
  logic                                  valid;
  logic                                  ready;
  logic [w2mp_pkg::LON_W-1:0]            pos_lon;
  logic signed [w2mp_pkg::LAT_W-1:0]     pos_lat;

  modport source (output valid, output pos_lon, output pos_lat, input ready);
  modport sink   (input valid, input pos_lon, input pos_lat, output ready);
endinterface

// ----- src/w2mp_pix_if.sv -----
// ----------------------------------------------------------------------------
// w2mp_pix_if
// Pixel channel: valid/ready handshake with grid cell and flags.
// ----------------------------------------------------------------------------
interface w2mp_pix_if;
  logic                       valid;
  logic                       ready;
  logic [w2mp_pkg::PIX_W-1:0] pixel_x;
  logic [w2mp_pkg::PIX_W-1:0] pixel_y;
  logic                       outside_map;
  logic                       bad_coordinate;

  modport source (output valid, output pixel_x, output pixel_y, output outside_map,
                  output bad_coordinate, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input outside_map,
                  input bad_coordinate, output ready);
endinterface

// ----- src/w2mp_cos.sv -----
// ----------------------------------------------------------------------------
// w2mp_cos
// Pipelined Q30 cosine of the mean latitude: scale to radians, square, then
// seven Horner steps, each a multiply, a reciprocal divide and a correction.
// ----------------------------------------------------------------------------
module w2mp_cos (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [w2mp_pkg::SUM_W-1:0]    sum_i,
  input  w2mp_pkg::side_t               side_i,
  output logic                          valid_o,
  output logic [w2mp_pkg::COS_W-1:0]    cos_o,
  output w2mp_pkg::side_t               side_o
);

  localparam int unsigned HN = w2mp_pkg::HORNER_N;

  logic                          k1_v_q;
  logic [w2mp_pkg::COS_W-1:0]    k1_x_q;
  w2mp_pkg::side_t               k1_s_q;
  logic                          k2_v_q;
  logic [w2mp_pkg::X2_W-1:0]     k2_x2_q;
  w2mp_pkg::side_t               k2_s_q;

  logic [HN-1:0]                 a_v_q, a_v_d;
  logic [w2mp_pkg::X2_W-1:0]     a_p_q  [HN];
  logic [w2mp_pkg::X2_W-1:0]     a_p_d  [HN];
  logic [w2mp_pkg::X2_W-1:0]     a_x2_q [HN];
  logic [w2mp_pkg::X2_W-1:0]     a_x2_d [HN];
  w2mp_pkg::side_t               a_s_q  [HN];
  w2mp_pkg::side_t               a_s_d  [HN];

  logic [HN-1:0]                 b_v_q, b_v_d;
  logic [w2mp_pkg::X2_W-1:0]     b_p_q  [HN];
  logic [w2mp_pkg::X2_W-1:0]     b_q0_q [HN];
  logic [w2mp_pkg::X2_W-1:0]     b_q0_d [HN];
  logic [w2mp_pkg::X2_W-1:0]     b_x2_q [HN];
  w2mp_pkg::side_t               b_s_q  [HN];

  logic [HN-1:0]                 c_v_q, c_v_d;
  logic [w2mp_pkg::COS_W-1:0]    c_r_q  [HN];
  logic [w2mp_pkg::COS_W-1:0]    c_r_d  [HN];
  logic [w2mp_pkg::X2_W-1:0]     c_x2_q [HN];
  w2mp_pkg::side_t               c_s_q  [HN];

  logic [50:0] x_mul;
  logic [61:0] x2_mul;

  // Scale to radians, then square
  assign x_mul  = 51'(sum_i) * 51'(w2mp_pkg::RAD_PER_DEG);
  assign x2_mul = 62'(k1_x_q) * 62'(k1_x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_v_q <= 1'b0;
      k2_v_q <= 1'b0;
      a_v_q  <= '0;
      b_v_q  <= '0;
      c_v_q  <= '0;
    end else if (en_i) begin
      k1_v_q <= valid_i;
      k2_v_q <= k1_v_q;
      a_v_q  <= a_v_d;
      b_v_q  <= b_v_d;
      c_v_q  <= c_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k1_x_q  <= x_mul[49:19];
      k1_s_q  <= side_i;
      k2_x2_q <= x2_mul[61:30];
      k2_s_q  <= k1_s_q;
      for (int k = 0; k < HN; k++) begin
        a_p_q[k]  <= a_p_d[k];
        a_x2_q[k] <= a_x2_d[k];
        a_s_q[k]  <= a_s_d[k];
        b_p_q[k]  <= a_p_q[k];
        b_q0_q[k] <= b_q0_d[k];
        b_x2_q[k] <= a_x2_q[k];
        b_s_q[k]  <= a_s_q[k];
        c_r_q[k]  <= c_r_d[k];
        c_x2_q[k] <= b_x2_q[k];
        c_s_q[k]  <= b_s_q[k];
      end
    end
  end

  // Horner steps: r = 1 - floor(floor(x2 * r) / d), clamped at zero
  always_comb begin
    logic                          v_in;
    logic [w2mp_pkg::X2_W-1:0]     x2_in;
    logic [w2mp_pkg::COS_W-1:0]    r_in;
    w2mp_pkg::side_t               s_in;
    logic [62:0]                   mul_a;
    logic [63:0]                   mul_b;
    logic [39:0]                   mul_c;
    logic [31:0]                   rem;
    logic [31:0]                   quo;
    for (int k = 0; k < HN; k++) begin
      if (k == 0) begin
        v_in  = k2_v_q;
        x2_in = k2_x2_q;
        r_in  = w2mp_pkg::ONE_Q30;
        s_in  = k2_s_q;
      end else begin
        v_in  = c_v_q[k-1];
        x2_in = c_x2_q[k-1];
        r_in  = c_r_q[k-1];
        s_in  = c_s_q[k-1];
      end
      mul_a     = 63'(x2_in) * 63'(r_in);
      a_v_d[k]  = v_in;
      a_p_d[k]  = mul_a[61:30];
      a_x2_d[k] = x2_in;
      a_s_d[k]  = s_in;

      // quotient estimate, low by at most one
      mul_b     = 64'(a_p_q[k]) * 64'(w2mp_pkg::HORNER_RCP[k]);
      b_v_d[k]  = a_v_q[k];
      b_q0_d[k] = mul_b[63:32];

      // correct the estimate and form the next term
      mul_c = 40'(b_q0_q[k]) * 40'(w2mp_pkg::HORNER_DIV[k]);
      rem   = b_p_q[k] - mul_c[31:0];
      quo   = b_q0_q[k] + 32'(rem >= 32'(w2mp_pkg::HORNER_DIV[k]));
      c_v_d[k] = b_v_q[k];
      c_r_d[k] = (quo > 32'(w2mp_pkg::ONE_Q30)) ? '0
               : 31'(32'(w2mp_pkg::ONE_Q30) - quo);
    end
  end

  assign valid_o = c_v_q[HN-1];
  assign cos_o   = c_r_q[HN-1];
  assign side_o  = c_s_q[HN-1];

endmodule

// ----- src/w2mp_grid.sv -----
// ----------------------------------------------------------------------------
// w2mp_grid
// Floor-divides the east and negated north offsets by the cell size, one
// quotient bit per stage, and forms the grid cell with the off-map check.
// ----------------------------------------------------------------------------
module w2mp_grid (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic signed [w2mp_pkg::OFS_W-1:0]    east_i,
  input  logic signed [w2mp_pkg::OFS_W-1:0]    south_i,
  input  logic                                 bad_i,
  input  logic [w2mp_pkg::LEN_W-1:0]           node_w_i,
  input  logic [w2mp_pkg::LEN_W-1:0]           node_h_i,
  output logic                                 valid_o,
  output w2mp_pkg::pix_t                       pix_o
);

  localparam int unsigned QW   = w2mp_pkg::QW;
  localparam int unsigned NX_W = w2mp_pkg::OFS_W - w2mp_pkg::CELL_SH;
  localparam int unsigned UW   = NX_W - 1;
  localparam int unsigned RW   = w2mp_pkg::LEN_W + QW;
  localparam logic [QW-1:0] LIM_NEG = QW'(w2mp_pkg::MAP_HALF - 1);
  localparam logic [QW-1:0] LIM_POS = QW'(w2mp_pkg::MAP_SIZE - w2mp_pkg::MAP_HALF - 1);
  localparam logic [w2mp_pkg::PIX_W-1:0] HALF_P  = w2mp_pkg::PIX_W'(w2mp_pkg::MAP_HALF);
  localparam logic [w2mp_pkg::PIX_W-1:0] HALF_M1 = w2mp_pkg::PIX_W'(w2mp_pkg::MAP_HALF - 1);

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] q;
    logic          neg;
    logic          ov;
  } lane_t;

  logic [w2mp_pkg::LEN_W-1:0] den_x, den_y;

  logic          g0_v_q;
  logic          g0_bad_q;
  lane_t         g0_x_q, g0_y_q;

  logic [QW-1:0] dv_q, dv_d;
  logic [QW-1:0] db_q, db_d;
  lane_t         dx_q [QW];
  lane_t         dx_d [QW];
  lane_t         dy_q [QW];
  lane_t         dy_d [QW];

  logic           out_v_q;
  w2mp_pkg::pix_t out_q, out_d;

  // A zero cell size acts as one
  assign den_x = (node_w_i == '0) ? w2mp_pkg::LEN_W'(1) : node_w_i;
  assign den_y = (node_h_i == '0) ? w2mp_pkg::LEN_W'(1) : node_h_i;

  // Fold a signed floor division into an unsigned one on the ones' complement
  function automatic lane_t lane_init(input logic [w2mp_pkg::OFS_W-1:0] n,
                                      input logic [w2mp_pkg::LEN_W-1:0] d);
    logic [NX_W-1:0] nx;
    logic [UW-1:0]   u;
    lane_t           l;
    nx    = n[w2mp_pkg::OFS_W-1:w2mp_pkg::CELL_SH];
    l.neg = nx[NX_W-1];
    u     = l.neg ? ~nx[UW-1:0] : nx[UW-1:0];
    l.ov  = (u >> QW) >= UW'(d);
    l.rem = RW'(u);
    l.q   = '0;
    return l;
  endfunction

  function automatic logic lane_in(input lane_t l);
    return !l.ov && (l.neg ? (l.q <= LIM_NEG) : (l.q <= LIM_POS));
  endfunction

  function automatic logic [w2mp_pkg::PIX_W-1:0] lane_pix(input lane_t l);
    return l.neg ? HALF_M1 - w2mp_pkg::PIX_W'(l.q) : HALF_P + w2mp_pkg::PIX_W'(l.q);
  endfunction

  // Restoring division, most significant quotient bit first
  always_comb begin
    lane_t         lx, ly;
    logic          v_in, b_in;
    logic [RW-1:0] shx, shy;
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        lx   = g0_x_q;
        ly   = g0_y_q;
        v_in = g0_v_q;
        b_in = g0_bad_q;
      end else begin
        lx   = dx_q[j-1];
        ly   = dy_q[j-1];
        v_in = dv_q[j-1];
        b_in = db_q[j-1];
      end
      shx = RW'(den_x) << (QW - 1 - j);
      shy = RW'(den_y) << (QW - 1 - j);
      if (lx.rem >= shx) begin
        lx.rem           = lx.rem - shx;
        lx.q[QW - 1 - j] = 1'b1;
      end
      if (ly.rem >= shy) begin
        ly.rem           = ly.rem - shy;
        ly.q[QW - 1 - j] = 1'b1;
      end
      dx_d[j] = lx;
      dy_d[j] = ly;
      dv_d[j] = v_in;
      db_d[j] = b_in;
    end
  end

  // Place the cell on the grid or flag it off the map
  always_comb begin
    if (lane_in(dx_q[QW-1]) && lane_in(dy_q[QW-1])) begin
      out_d.pixel_x     = lane_pix(dx_q[QW-1]);
      out_d.pixel_y     = lane_pix(dy_q[QW-1]);
      out_d.outside_map = 1'b0;
    end else begin
      out_d.pixel_x     = w2mp_pkg::PIX_NONE;
      out_d.pixel_y     = w2mp_pkg::PIX_NONE;
      out_d.outside_map = 1'b1;
    end
    out_d.bad_coordinate = db_q[QW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g0_v_q  <= 1'b0;
      dv_q    <= '0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      g0_v_q  <= valid_i;
      dv_q    <= dv_d;
      out_v_q <= dv_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g0_x_q   <= lane_init(east_i, den_x);
      g0_y_q   <= lane_init(south_i, den_y);
      g0_bad_q <= bad_i;
      db_q     <= db_d;
      for (int j = 0; j < QW; j++) begin
        dx_q[j] <= dx_d[j];
        dy_q[j] <= dy_d[j];
      end
      out_q <= out_d;
    end
  end

  assign valid_o = out_v_q;
  assign pix_o   = out_q;

endmodule

// ----- src/world_to_map_pixel.sv -----
// ----------------------------------------------------------------------------
// world_to_map_pixel
// Maps a longitude/latitude position onto a square grid centred on a
// configured point (equirectangular projection).
// ----------------------------------------------------------------------------
// Takes one position item per clock while ready is high and returns one pixel
// item per position, in order. Items pass through input capture and wrap, the
// cosine pipeline (radian scale, square, seven Horner steps of three stages
// each), the east and north products, and the cell-size dividers with their
// set-up, quotient-bit and result stages. When the sink stalls, the finished
// pixel is parked in a one-entry output stage and the whole pipeline holds;
// ready stays low for as long as a pixel is parked. Configuration writes are
// taken whenever the write enable is high and must only be made while no item
// is in flight.
module world_to_map_pixel (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  w2mp_pos_if.sink                            pos_i,
  w2mp_pix_if.source                          pix_o,
  input  logic                                cfg_we_i,
  input  logic [w2mp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [w2mp_pkg::CFG_W-1:0]          cfg_data_i
);

  logic [w2mp_pkg::LON_W-1:0]          center_lon_q;
  logic signed [w2mp_pkg::LAT_W-1:0]   center_lat_q;
  logic [w2mp_pkg::LEN_W-1:0]          node_w_q;
  logic [w2mp_pkg::LEN_W-1:0]          node_h_q;
  logic [w2mp_pkg::MPD_W-1:0]          mpd_q;

  logic en;

  logic                                s0_v_q;
  logic [w2mp_pkg::LON_W-1:0]          s0_lon_q;
  logic signed [w2mp_pkg::LAT_W-1:0]   s0_lat_q;

  logic                                s1_v_q;
  w2mp_pkg::side_t                     s1_side_q, s1_side_d;
  logic [w2mp_pkg::SUM_W-1:0]          s1_sum_q, s1_sum_d;

  logic                                cos_v;
  logic [w2mp_pkg::COS_W-1:0]          cos_c;
  w2mp_pkg::side_t                     cos_side;

  logic                                e1_v_q;
  logic signed [w2mp_pkg::OFS_W-1:0]   e1_a_q, e1_a_d;
  logic signed [w2mp_pkg::OFS_W-1:0]   e1_n_q, e1_n_d;
  logic [w2mp_pkg::COS_W-1:0]          e1_c_q;
  logic                                e1_bad_q;

  logic                                e2_v_q;
  logic [55:0]                         e2_t_q;
  logic [54:0]                         e2_l_q;
  logic                                e2_neg_q;
  logic signed [w2mp_pkg::OFS_W-1:0]   e2_s_q;
  logic                                e2_bad_q;
  logic [48:0]                         e2_mag;

  logic                                e3_v_q;
  logic signed [w2mp_pkg::OFS_W-1:0]   e3_east_q, e3_east_d;
  logic signed [w2mp_pkg::OFS_W-1:0]   e3_s_q;
  logic                                e3_bad_q;

  logic                                grid_v;
  w2mp_pkg::pix_t                      grid_pix;

  logic                                skid_q, skid_d;
  w2mp_pkg::pix_t                      skid_pix_q;
  w2mp_pkg::pix_t                      out_pix;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_lon_q <= '0;
      center_lat_q <= '0;
      node_w_q     <= w2mp_pkg::NODE_RST;
      node_h_q     <= w2mp_pkg::NODE_RST;
      mpd_q        <= w2mp_pkg::MPD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        w2mp_pkg::REG_CENTER_LON: center_lon_q <= cfg_data_i;
        w2mp_pkg::REG_CENTER_LAT: center_lat_q <= cfg_data_i[w2mp_pkg::LAT_W-1:0];
        w2mp_pkg::REG_NODE_W:     node_w_q     <= cfg_data_i[w2mp_pkg::LEN_W-1:0];
        w2mp_pkg::REG_NODE_H:     node_h_q     <= cfg_data_i[w2mp_pkg::LEN_W-1:0];
        w2mp_pkg::REG_MPD:        mpd_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline advances unless the output stage holds a waiting item
  assign en          = !skid_q;
  assign pos_i.ready = en;

  // Wrap the longitude difference, form latitude sum and difference, flag bad inputs
  always_comb begin
    logic signed [26:0] d0;
    logic signed [26:0] dw;
    logic signed [24:0] ls;
    logic [24:0]        la;
    d0 = $signed({2'b00, s0_lon_q}) - $signed({2'b00, center_lon_q});
    if (d0 < -w2mp_pkg::LON_180S) begin
      dw = d0 + w2mp_pkg::LON_360S;
    end else if (d0 >= w2mp_pkg::LON_180S) begin
      dw = d0 - w2mp_pkg::LON_360S;
    end else begin
      dw = d0;
    end
    ls = 25'(s0_lat_q) + 25'(center_lat_q);
    la = ls[24] ? 25'(-ls) : 25'(ls);
    s1_sum_d = (la > 25'(w2mp_pkg::DEG90X2)) ? w2mp_pkg::DEG90X2
             : la[w2mp_pkg::SUM_W-1:0];
    s1_side_d.dlon = dw[w2mp_pkg::DLT_W-1:0];
    s1_side_d.dlat = 25'(s0_lat_q) - 25'(center_lat_q);
    s1_side_d.bad  = (s0_lon_q >= w2mp_pkg::DEG360) || (center_lon_q >= w2mp_pkg::DEG360)
                  || (s0_lat_q < w2mp_pkg::LAT_MIN) || (s0_lat_q > w2mp_pkg::LAT_MAX)
                  || (center_lat_q < w2mp_pkg::LAT_MIN)
                  || (center_lat_q > w2mp_pkg::LAT_MAX);
  end

  w2mp_cos u_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_v_q),
    .sum_i   (s1_sum_q),
    .side_i  (s1_side_q),
    .valid_o (cos_v),
    .cos_o   (cos_c),
    .side_o  (cos_side)
  );

  // Scale the differences to metres
  assign e1_a_d = $signed(cos_side.dlon) * $signed({1'b0, mpd_q});
  assign e1_n_d = $signed(cos_side.dlat) * $signed({1'b0, mpd_q});

  // Magnitude of east offset, split for the cosine product
  assign e2_mag = e1_a_q[w2mp_pkg::OFS_W-1] ? 49'(-e1_a_q) : 49'(e1_a_q);

  // Recombine the split product and restore the sign
  always_comb begin
    logic [55:0] lo;
    logic [49:0] emag;
    lo   = 56'({e2_t_q[5:0], 24'd0}) + 56'(e2_l_q);
    emag = e2_t_q[55:6] + 50'(lo[55:30]);
    e3_east_d = e2_neg_q ? -$signed(emag) : $signed(emag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      e1_v_q <= 1'b0;
      e2_v_q <= 1'b0;
      e3_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= pos_i.valid;
      s1_v_q <= s0_v_q;
      e1_v_q <= cos_v;
      e2_v_q <= e1_v_q;
      e3_v_q <= e2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_lon_q  <= pos_i.pos_lon;
      s0_lat_q  <= pos_i.pos_lat;
      s1_side_q <= s1_side_d;
      s1_sum_q  <= s1_sum_d;
      e1_a_q    <= e1_a_d;
      e1_n_q    <= e1_n_d;
      e1_c_q    <= cos_c;
      e1_bad_q  <= cos_side.bad;
      e2_t_q    <= 56'(e2_mag[48:24]) * 56'(e1_c_q);
      e2_l_q    <= 55'(e2_mag[23:0]) * 55'(e1_c_q);
      e2_neg_q  <= e1_a_q[w2mp_pkg::OFS_W-1];
      e2_s_q    <= -e1_n_q;
      e2_bad_q  <= e1_bad_q;
      e3_east_q <= e3_east_d;
      e3_s_q    <= e2_s_q;
      e3_bad_q  <= e2_bad_q;
    end
  end

  w2mp_grid u_grid (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (e3_v_q),
    .east_i   (e3_east_q),
    .south_i  (e3_s_q),
    .bad_i    (e3_bad_q),
    .node_w_i (node_w_q),
    .node_h_i (node_h_q),
    .valid_o  (grid_v),
    .pix_o    (grid_pix)
  );

  // Output stage: park the last item when the sink stalls
  assign skid_d = skid_q ? !pix_o.ready : (grid_v && !pix_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_q <= 1'b0;
    end else begin
      skid_q <= skid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      skid_pix_q <= grid_pix;
    end
  end

  assign out_pix              = skid_q ? skid_pix_q : grid_pix;
  assign pix_o.valid          = skid_q || grid_v;
  assign pix_o.pixel_x        = out_pix.pixel_x;
  assign pix_o.pixel_y        = out_pix.pixel_y;
  assign pix_o.outside_map    = out_pix.outside_map;
  assign pix_o.bad_coordinate = out_pix.bad_coordinate;

endmodule

// ----- src/w2mp_chk.sv -----
// ----------------------------------------------------------------------------
// w2mp_chk
// Port-level checks for the world-to-map pixel block, bound to the top level.
// ----------------------------------------------------------------------------
module w2mp_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       pos_ready_i,
  input logic                       pix_valid_i,
  input logic                       pix_ready_i,
  input logic [w2mp_pkg::PIX_W-1:0] pixel_x_i,
  input logic [w2mp_pkg::PIX_W-1:0] pixel_y_i,
  input logic                       outside_map_i,
  input logic                       bad_coordinate_i
);

  // Hold a stalled item unchanged
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && !pix_ready_i |=> pix_valid_i && $stable(pixel_x_i)
      && $stable(pixel_y_i) && $stable(outside_map_i) && $stable(bad_coordinate_i))
    else $error("pixel item changed while stalled");

  // Off-map cells carry the marker in both coordinates
  a_off_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && outside_map_i |-> pixel_x_i == w2mp_pkg::PIX_NONE
      && pixel_y_i == w2mp_pkg::PIX_NONE)
    else $error("off-map item without marker");

  // On-map cells lie inside the grid
  a_on_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && !outside_map_i |-> 32'(pixel_x_i) < w2mp_pkg::MAP_SIZE
      && 32'(pixel_y_i) < w2mp_pkg::MAP_SIZE)
    else $error("on-map item beyond grid");

  // Input backpressure only while a result waits
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pos_ready_i |-> pix_valid_i)
    else $error("input held off with no result waiting");

endmodule

bind world_to_map_pixel w2mp_chk u_w2mp_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .pos_ready_i      (pos_i.ready),
  .pix_valid_i      (pix_o.valid),
  .pix_ready_i      (pix_o.ready),
  .pixel_x_i        (pix_o.pixel_x),
  .pixel_y_i        (pix_o.pixel_y),
  .outside_map_i    (pix_o.outside_map),
  .bad_coordinate_i (pix_o.bad_coordinate)
);
